// ===== design/tcds_pkg.sv =====
// ---------------------------------------------------------------------------
// tcds_pkg: shared types and constants for call-duration statistics
// Field widths, status codes, mode codes and the request and response structs.
// ---------------------------------------------------------------------------
package tcds_pkg;

  localparam int unsigned ThreadSlotsDef   = 128;
  localparam int unsigned FunctionCountDef = 16;
  localparam int unsigned LockSlotsDef     = 64;

  localparam int unsigned TagW   = 64;
  localparam int unsigned StampW = 64;
  localparam int unsigned CountW = 32;
  localparam int unsigned FidW   = 4;
  localparam int unsigned IdxW   = 7;
  localparam int unsigned SlotsW = 8;

  localparam logic [1:0] ModeEvent  = 2'd0;
  localparam logic [1:0] ModeFunc   = 2'd1;
  localparam logic [1:0] ModeLock   = 2'd2;
  localparam logic [1:0] ModeThread = 2'd3;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StMismatch = 3'd1;
  localparam logic [2:0] StLockFull = 3'd2;
  localparam logic [2:0] StThrFull  = 3'd3;
  localparam logic [2:0] StBadIdx   = 3'd4;

  localparam logic [CountW-1:0] CntMax = '1;

  // one input beat as carried from the front queue to the back part
  typedef struct packed {
    logic [1:0]        mode;
    logic [TagW-1:0]   tag;
    logic              kind;
    logic [FidW-1:0]   fid;
    logic [StampW-1:0] ts;
    logic [TagW-1:0]   key;
    logic [IdxW-1:0]   idx;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [StampW-1:0] dur;
    logic [CountW-1:0] count;
    logic [StampW-1:0] total;
    logic [StampW-1:0] min_t;
    logic [StampW-1:0] max_t;
    logic [TagW-1:0]   key;
    logic [SlotsW-1:0] slots;
  } rsp_t;

  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] c);
    sat_inc = (c == CntMax) ? CntMax : c + 1'b1;
  endfunction

endpackage

// ===== design/tcds_fifo.sv =====
// ---------------------------------------------------------------------------
// tcds_fifo: small register queue
// Two-entry queue used between the front, the back part and the result port.
// ---------------------------------------------------------------------------
module tcds_fifo #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);
  logic [Width-1:0] mem_q [2];
  logic             wp_q, rp_q;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rp_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + 2'd1;
    if (!do_push && do_pop) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) wp_q <= ~wp_q;
      if (do_pop) rp_q <= ~rp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wp_q] <= data_i;
  end
endmodule

// ===== design/tcds_engine.sv =====
// ---------------------------------------------------------------------------
// tcds_engine: back part of the statistics block
// Sequencer that searches the thread and lock tables one slot a cycle and
// does the read-modify-write of thread, function and lock entries and serves their reads.
// ---------------------------------------------------------------------------
module tcds_engine #(
  parameter int unsigned ThreadSlots   = tcds_pkg::ThreadSlotsDef,
  parameter int unsigned FunctionCount = tcds_pkg::FunctionCountDef,
  parameter int unsigned LockSlots     = tcds_pkg::LockSlotsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [15:0]    mask_i,
  input  logic           req_valid_i,
  input  tcds_pkg::req_t req_i,
  output logic           req_pop_o,
  output logic           rsp_push_o,
  output tcds_pkg::rsp_t rsp_o,
  input  logic           rsp_full_i
);
  import tcds_pkg::*;

  localparam int unsigned TW = (ThreadSlots > 1) ? $clog2(ThreadSlots) : 1;
  localparam int unsigned LW = (LockSlots > 1) ? $clog2(LockSlots) : 1;
  localparam int unsigned FW = (FunctionCount > 1) ? $clog2(FunctionCount) : 1;
  localparam int unsigned TCW = $clog2(ThreadSlots + 1);
  localparam int unsigned LCW = $clog2(LockSlots + 1);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b0_0000_0001,
    S_TSRCH  = 9'b0_0000_0010,
    S_TRD    = 9'b0_0000_0100,
    S_TUPD   = 9'b0_0000_1000,
    S_FUPD   = 9'b0_0001_0000,
    S_LSRCH  = 9'b0_0010_0000,
    S_LRD    = 9'b0_0100_0000,
    S_LUPD   = 9'b0_1000_0000,
    S_DONE   = 9'b1_0000_0000
  } state_e;

  state_e state_q, state_d;

  // thread table memories
  logic [TagW-1:0]   t_tag   [ThreadSlots];
  logic [FidW:0]     t_open  [ThreadSlots];
  logic [StampW-1:0] t_entry [ThreadSlots];
  logic [CountW-1:0] t_cnt   [ThreadSlots];
  logic [StampW-1:0] t_min   [ThreadSlots];
  logic [StampW-1:0] t_max   [ThreadSlots];
  // lock table memories
  logic [TagW-1:0]   l_key   [LockSlots];
  logic [CountW-1:0] l_cnt   [LockSlots];
  logic [StampW-1:0] l_tot   [LockSlots];
  logic [StampW-1:0] l_min   [LockSlots];
  logic [StampW-1:0] l_max   [LockSlots];
  // function table, small and indexed by the fid field for updates, by idx for reads
  logic [CountW-1:0] f_cnt   [FunctionCount];
  logic [StampW-1:0] f_tot   [FunctionCount];
  logic [StampW-1:0] f_min   [FunctionCount];
  logic [StampW-1:0] f_max   [FunctionCount];

  logic [TCW-1:0] threads_used_q;
  logic [LCW-1:0] locks_used_q;
  logic [TCW-1:0] scan_q;
  logic           hit_v_q;
  req_t           r_q;
  rsp_t           rsp_q;
  logic [TW-1:0]  slot_q;
  logic [LW-1:0]  lslot_q;
  logic           new_q;
  logic [StampW-1:0] dur_q;

  // registered reads of the addressed thread and lock slots
  logic [TagW-1:0]   rd_ttag_q;
  logic [FidW:0]     rd_topen_q;
  logic [StampW-1:0] rd_tentry_q, rd_tmin_q, rd_tmax_q;
  logic [CountW-1:0] rd_tcnt_q;
  logic [TagW-1:0]   rd_lkey_q;
  logic [StampW-1:0] rd_ltot_q, rd_lmin_q, rd_lmax_q;
  logic [CountW-1:0] rd_lcnt_q;

  logic [TW-1:0]     t_raddr;
  logic [LW-1:0]     l_raddr;
  logic [FW-1:0]     fid_f, fidx;
  logic              fid_ok;
  logic              t_hit, t_end, t_full, l_hit, l_end, l_full;
  logic              t_match, t_wr, l_wr;
  logic [FidW:0]     cur_topen, nxt_topen;
  logic [CountW-1:0] cur_tcnt, cur_lcnt;
  logic [StampW-1:0] cur_tmin, cur_tmax, cur_ltot, cur_lmin, cur_lmax, dur_c;

  assign fid_f  = r_q.fid[FW-1:0];
  assign fidx   = r_q.idx[FW-1:0];
  assign fid_ok = {1'b0, r_q.fid} < (FidW+1)'(FunctionCount);

  assign t_raddr = (state_q == S_TSRCH) ? scan_q[TW-1:0] : slot_q;
  assign l_raddr = (state_q == S_LSRCH) ? scan_q[LW-1:0] : lslot_q;

  // compare uses the registered read of the previous slot: a hit names slot scan_q-1
  assign t_hit  = hit_v_q && rd_ttag_q == r_q.tag;
  assign t_end  = 32'(scan_q) >= 32'(threads_used_q);
  assign t_full = 32'(threads_used_q) >= ThreadSlots;
  assign l_hit  = hit_v_q && rd_lkey_q == r_q.key;
  assign l_end  = 32'(scan_q) >= 32'(locks_used_q);
  assign l_full = 32'(locks_used_q) >= LockSlots;

  // a freshly claimed slot starts from cleared values
  assign cur_tcnt  = new_q ? '0 : rd_tcnt_q;
  assign cur_tmin  = new_q ? '1 : rd_tmin_q;
  assign cur_tmax  = new_q ? '0 : rd_tmax_q;
  assign cur_topen = new_q ? (FidW+1)'(FunctionCount) : rd_topen_q;
  assign cur_lcnt  = new_q ? '0 : rd_lcnt_q;
  assign cur_ltot  = new_q ? '0 : rd_ltot_q;
  assign cur_lmin  = new_q ? '1 : rd_lmin_q;
  assign cur_lmax  = new_q ? '0 : rd_lmax_q;

  assign t_match = r_q.kind && fid_ok && cur_topen == {1'b0, r_q.fid};
  assign dur_c   = r_q.ts - rd_tentry_q;

  always_comb begin
    if (!r_q.kind) begin
      nxt_topen = fid_ok ? {1'b0, r_q.fid} : (FidW+1)'(FunctionCount);
    end else if (t_match) begin
      nxt_topen = (FidW+1)'(FunctionCount);
    end else begin
      nxt_topen = cur_topen;
    end
  end

  assign t_wr = state_q == S_TUPD && r_q.mode == ModeEvent;
  assign l_wr = state_q == S_LUPD && r_q.mode == ModeEvent;

  assign req_pop_o  = state_q == S_IDLE && req_valid_i;
  assign rsp_push_o = state_q == S_DONE && !rsp_full_i;
  assign rsp_o      = rsp_q;

  always_ff @(posedge clk_i) begin
    if (t_wr) begin
      if (new_q) t_tag[slot_q] <= r_q.tag;
      t_open[slot_q] <= nxt_topen;
      if (!r_q.kind) t_entry[slot_q] <= r_q.ts;
      t_cnt[slot_q] <= sat_inc(cur_tcnt);
      t_min[slot_q] <= (r_q.ts < cur_tmin) ? r_q.ts : cur_tmin;
      t_max[slot_q] <= (r_q.ts > cur_tmax) ? r_q.ts : cur_tmax;
    end
    rd_ttag_q   <= t_tag[t_raddr];
    rd_topen_q  <= t_open[t_raddr];
    rd_tentry_q <= t_entry[t_raddr];
    rd_tcnt_q   <= t_cnt[t_raddr];
    rd_tmin_q   <= t_min[t_raddr];
    rd_tmax_q   <= t_max[t_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (l_wr) begin
      if (new_q) l_key[lslot_q] <= r_q.key;
      l_cnt[lslot_q] <= sat_inc(cur_lcnt);
      l_tot[lslot_q] <= cur_ltot + dur_q;
      l_min[lslot_q] <= (dur_q < cur_lmin) ? dur_q : cur_lmin;
      l_max[lslot_q] <= (dur_q > cur_lmax) ? dur_q : cur_lmax;
    end
    rd_lkey_q <= l_key[l_raddr];
    rd_lcnt_q <= l_cnt[l_raddr];
    rd_ltot_q <= l_tot[l_raddr];
    rd_lmin_q <= l_min[l_raddr];
    rd_lmax_q <= l_max[l_raddr];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          if (req_i.mode == ModeEvent) state_d = S_TSRCH;
          else if (req_i.mode == ModeFunc) state_d = S_FUPD;
          else if (req_i.mode == ModeLock) state_d = S_LRD;
          else state_d = S_TRD;
        end
      end
      S_TSRCH: begin
        if (t_hit) state_d = S_TRD;
        else if (t_end) state_d = t_full ? S_DONE : S_TRD;
      end
      S_TRD:   state_d = S_TUPD;
      S_TUPD:  state_d = (r_q.mode == ModeEvent && t_match) ? S_FUPD : S_DONE;
      S_FUPD:  state_d = (r_q.mode == ModeEvent && mask_i[r_q.fid]) ? S_LSRCH : S_DONE;
      S_LSRCH: begin
        if (l_hit) state_d = S_LRD;
        else if (l_end) state_d = l_full ? S_DONE : S_LRD;
      end
      S_LRD:   state_d = S_LUPD;
      S_LUPD:  state_d = S_DONE;
      S_DONE:  if (!rsp_full_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      threads_used_q <= '0;
      locks_used_q   <= '0;
      scan_q         <= '0;
      hit_v_q        <= 1'b0;
      new_q          <= 1'b0;
      slot_q         <= '0;
      lslot_q        <= '0;
      r_q            <= '0;
      rsp_q          <= '0;
      dur_q          <= '0;
      for (int i = 0; i < FunctionCount; i++) begin
        f_cnt[i] <= '0;
        f_tot[i] <= '0;
        f_min[i] <= '1;
        f_max[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      case (state_q)
        S_IDLE: begin
          if (req_valid_i) begin
            r_q     <= req_i;
            rsp_q   <= '0;
            scan_q  <= '0;
            hit_v_q <= 1'b0;
            new_q   <= 1'b0;
            slot_q  <= req_i.idx[TW-1:0];
            lslot_q <= req_i.idx[LW-1:0];
          end
        end
        S_TSRCH: begin
          if (t_hit) begin
            slot_q <= TW'(scan_q - 1'b1);
          end else if (t_end) begin
            if (t_full) begin
              rsp_q.status <= StThrFull;
            end else begin
              slot_q         <= threads_used_q[TW-1:0];
              new_q          <= 1'b1;
              threads_used_q <= threads_used_q + 1'b1;
            end
          end else begin
            scan_q  <= scan_q + 1'b1;
            hit_v_q <= 1'b1;
          end
        end
        S_TUPD: begin
          if (r_q.mode == ModeEvent) begin
            if (r_q.kind && !t_match) rsp_q.status <= StMismatch;
            if (t_match) begin
              dur_q     <= dur_c;
              rsp_q.dur <= dur_c;
            end
          end else begin
            rsp_q.slots <= SlotsW'(threads_used_q);
            if (32'(r_q.idx) < 32'(threads_used_q)) begin
              rsp_q.count <= rd_tcnt_q;
              rsp_q.min_t <= rd_tmin_q;
              rsp_q.max_t <= rd_tmax_q;
              rsp_q.key   <= rd_ttag_q;
            end else begin
              rsp_q.status <= StBadIdx;
            end
          end
        end
        S_FUPD: begin
          if (r_q.mode == ModeEvent) begin
            f_cnt[fid_f] <= sat_inc(f_cnt[fid_f]);
            f_tot[fid_f] <= f_tot[fid_f] + dur_q;
            if (dur_q < f_min[fid_f]) f_min[fid_f] <= dur_q;
            if (dur_q > f_max[fid_f]) f_max[fid_f] <= dur_q;
            if (mask_i[r_q.fid]) begin
              scan_q  <= '0;
              hit_v_q <= 1'b0;
            end
          end else begin
            if (32'(r_q.idx) < FunctionCount) begin
              rsp_q.count <= f_cnt[fidx];
              rsp_q.total <= f_tot[fidx];
              rsp_q.min_t <= f_min[fidx];
              rsp_q.max_t <= f_max[fidx];
            end else begin
              rsp_q.status <= StBadIdx;
            end
          end
        end
        S_LSRCH: begin
          if (l_hit) begin
            lslot_q <= LW'(scan_q - 1'b1);
            new_q   <= 1'b0;
          end else if (l_end) begin
            if (l_full) begin
              rsp_q.status <= StLockFull;
            end else begin
              lslot_q      <= locks_used_q[LW-1:0];
              new_q        <= 1'b1;
              locks_used_q <= locks_used_q + 1'b1;
            end
          end else begin
            scan_q  <= scan_q + 1'b1;
            hit_v_q <= 1'b1;
          end
        end
        S_LUPD: begin
          if (r_q.mode == ModeLock) begin
            rsp_q.slots <= SlotsW'(locks_used_q);
            if (32'(r_q.idx) < 32'(locks_used_q)) begin
              rsp_q.count <= rd_lcnt_q;
              rsp_q.total <= rd_ltot_q;
              rsp_q.min_t <= rd_lmin_q;
              rsp_q.max_t <= rd_lmax_q;
              rsp_q.key   <= rd_lkey_q;
            end else begin
              rsp_q.status <= StBadIdx;
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== design/trace_call_duration_stats.sv =====
// ---------------------------------------------------------------------------
// trace_call_duration_stats: per-function, per-lock and per-thread statistics
// An input queue feeds a sequencer that does table searches and updates,
// whose results drain through an output queue.
// ---------------------------------------------------------------------------
// path, input beat to poppable result: input queue, engine states, output queue; a
// function read passes S_FUPD, a thread or lock read S_TRD and S_TUPD or S_LRD and
// S_LUPD, an event the thread search over the used slots up to the match, then S_TRD
// and S_TUPD; a matched exit adds S_FUPD, a lock-type one the lock search, S_LRD
// and S_LUPD; all end in S_DONE; one item at a time; a full result queue holds it
// reset: async active low; used counts and function stats clear, slots clear on claim
module trace_call_duration_stats #(
  parameter int unsigned ThreadSlots   = tcds_pkg::ThreadSlotsDef,
  parameter int unsigned FunctionCount = tcds_pkg::FunctionCountDef,
  parameter int unsigned LockSlots     = tcds_pkg::LockSlotsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  mode_i,
  input  logic [63:0] thread_tag_i,
  input  logic        event_kind_i,
  input  logic [3:0]  function_id_i,
  input  logic [63:0] timestamp_i,
  input  logic [63:0] lock_key_i,
  input  logic [6:0]  read_index_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status_o,
  output logic [63:0] call_duration_o,
  output logic [31:0] entry_count_o,
  output logic [63:0] total_time_o,
  output logic [63:0] min_time_o,
  output logic [63:0] max_time_o,
  output logic [63:0] entry_key_o,
  output logic [7:0]  slots_used_o
);
  import tcds_pkg::*;

  localparam logic [1:0] RegMask = 2'd0;

  logic [15:0] mask_q;
  req_t req_in, req_q;
  rsp_t rsp_d, rsp_q;
  logic req_empty, req_pop, rsp_push, rsp_full;

  assign pready = 1'b1;
  assign prdata = (paddr == RegMask) ? {16'h0, mask_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (psel && penable && pwrite && paddr == RegMask) begin
      mask_q <= pwdata[15:0];
    end
  end

  assign req_in = '{mode: mode_i, tag: thread_tag_i, kind: event_kind_i,
                    fid: function_id_i, ts: timestamp_i, key: lock_key_i,
                    idx: read_index_i};

  tcds_fifo #(.Width($bits(req_t))) u_in_q (
    .clk_i, .rst_ni, .push_i(push), .data_i(req_in), .full_o(full),
    .pop_i(req_pop), .data_o(req_q), .empty_o(req_empty)
  );

  tcds_engine #(
    .ThreadSlots(ThreadSlots), .FunctionCount(FunctionCount), .LockSlots(LockSlots)
  ) u_engine (
    .clk_i, .rst_ni, .mask_i(mask_q), .req_valid_i(!req_empty), .req_i(req_q),
    .req_pop_o(req_pop), .rsp_push_o(rsp_push), .rsp_o(rsp_d), .rsp_full_i(rsp_full)
  );

  tcds_fifo #(.Width($bits(rsp_t))) u_out_q (
    .clk_i, .rst_ni, .push_i(rsp_push), .data_i(rsp_d), .full_o(rsp_full),
    .pop_i(pop), .data_o(rsp_q), .empty_o(empty)
  );

  assign status_o        = rsp_q.status;
  assign call_duration_o = rsp_q.dur;
  assign entry_count_o   = rsp_q.count;
  assign total_time_o    = rsp_q.total;
  assign min_time_o      = rsp_q.min_t;
  assign max_time_o      = rsp_q.max_t;
  assign entry_key_o     = rsp_q.key;
  assign slots_used_o    = rsp_q.slots;
endmodule
